// File: src/lfid_pkg.sv
// lfid_pkg: shared constants, codes and types of the lowest-free id allocator
// depends on nothing; used by the interfaces, the finder and the top level
`default_nettype none

package lfid_pkg;

   // id and bitmap geometry
   localparam int ID_W             = 8;
   localparam int ID_SPACE         = 256;
   localparam int WORD_W           = 16;
   localparam int WORD_IW          = 4;
   localparam int ID_COUNT_DEFAULT = 256;

   // request codes
   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_RELEASE = 2'd1,
      OP_QUERY   = 2'd2
   } op_type;

   // control sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL
   } state_type;

   // lowest clear bit of one bitmap row
   typedef struct packed {
      logic               found;
      logic [WORD_IW-1:0] idx;
   } bit_hit_type;

endpackage

`default_nettype wire

// File: src/lfid_if.sv
// lfid_req_if / lfid_rsp_if: valid-ready channels of the allocator
// depends on lfid_pkg for the field widths
`default_nettype none

interface lfid_req_if;
   logic                      valid;
   logic                      ready;
   logic [1:0]                opcode;
   logic                      hint_valid;
   logic [lfid_pkg::ID_W-1:0] id_value;

   modport source (output valid, opcode, hint_valid, id_value, input ready);
   modport sink   (input valid, opcode, hint_valid, id_value, output ready);
endinterface

interface lfid_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [lfid_pkg::ID_W-1:0] granted_id;
   logic                      is_used;
   logic                      pool_full;

   modport source (output valid, granted_id, is_used, pool_full, input ready);
   modport sink   (input valid, granted_id, is_used, pool_full, output ready);
endinterface

`default_nettype wire

// File: src/lfid_find.sv
// lfid_find: priority encoders for the lowest non-full row and lowest free bit
// depends on lfid_pkg
`default_nettype none

module lfid_find #(
   parameter int ROWS  = 16,
   parameter int ROW_W = 4
) (
   input  wire logic [ROWS-1:0]             row_full,
   input  wire logic [lfid_pkg::WORD_W-1:0] word,
   output logic                             row_found,
   output logic [ROW_W-1:0]                 row_idx,
   output lfid_pkg::bit_hit_type            bit_hit
);

   // lowest row whose summary flag says a free id remains
   always_comb begin
      row_found = 1'b0;
      row_idx   = '0;
      for (int r = ROWS - 1; r >= 0; r--) begin
         if (!row_full[r]) begin
            row_found = 1'b1;
            row_idx   = ROW_W'(r);
         end
      end
   end

   // lowest clear bit in the row just read
   always_comb begin
      bit_hit = '0;
      for (int b = lfid_pkg::WORD_W - 1; b >= 0; b--) begin
         if (!word[b]) begin
            bit_hit.found = 1'b1;
            bit_hit.idx   = lfid_pkg::WORD_IW'(b);
         end
      end
   end

endmodule

`default_nettype wire

// File: src/lowest_free_id_allocator.sv
// lowest_free_id_allocator: top level, bitmap memory, row summary and sequencer
// depends on lfid_pkg, lfid_if and lfid_find
`default_nettype none

// Allocator of numeric ids 0 .. min(ID_COUNT,256)-1. The used bitmap lives in a
// memory of 16-bit rows with a registered read; a flip-flop per row marks rows
// written since reset (unwritten rows read as all free) and another marks full
// rows, so no clearing pass follows reset. Each request is one beat in and one
// beat out; requests are handled one at a time. A request is accepted, its row
// is read from memory, and it is evaluated and written back once the response
// register is free; an acquire whose hint is already taken needs a second read,
// of the lowest non-full row, as the memory has a single read port. The response
// sits in an output register, so a new request is taken while it waits.
module lowest_free_id_allocator #(
   parameter int ID_COUNT = lfid_pkg::ID_COUNT_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   lfid_req_if.sink    req_ch,
   lfid_rsp_if.source  rsp_ch
);

   localparam int POOL      = (ID_COUNT < lfid_pkg::ID_SPACE) ? ID_COUNT : lfid_pkg::ID_SPACE;
   localparam int WW        = lfid_pkg::WORD_W;
   localparam int ROWS      = (POOL + WW - 1) / WW;
   localparam int ROW_W     = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int LAST_BITS = POOL - (ROWS - 1) * WW;
   localparam logic [WW:0]   LAST_ONES = ((WW + 1)'(1) << LAST_BITS) - (WW + 1)'(1);
   localparam logic [WW-1:0] PAD_MASK  = ~LAST_ONES[WW-1:0];
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [lfid_pkg::ID_W:0] POOL_L = (lfid_pkg::ID_W + 1)'(POOL);

   // sequencer and request registers
   lfid_pkg::state_type       state_ff, state_in;
   logic [1:0]                op_ff, op_in;
   logic [lfid_pkg::ID_W-1:0] id_ff, id_in;
   logic                      at_id_row_ff, at_id_row_in;
   logic [ROW_W-1:0]          addr_ff, addr_in;

   // bitmap memory and per-row flags
   logic [WW-1:0]   used_mem [ROWS];
   logic [WW-1:0]   rdata_ff;
   logic [ROWS-1:0] rowvld_ff;
   logic [ROWS-1:0] rowfull_ff;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [lfid_pkg::ID_W-1:0] grant_ff, grant_in;
   logic                      used_ff, used_in;
   logic                      full_ff, full_in;

   // datapath
   logic [WW-1:0]         word, pad, eff, wr_word;
   logic                  wr_en, done;
   logic                  row_found;
   logic [ROW_W-1:0]      row_idx;
   lfid_pkg::bit_hit_type bit_hit;
   logic                  req_in_pool, id_in_pool;
   logic [ROW_W-1:0]      req_row;

   // row as held in memory, padded with used bits past the pool
   assign word = rowvld_ff[addr_ff] ? rdata_ff : '0;
   assign pad  = (addr_ff == LAST_ROW) ? PAD_MASK : '0;
   assign eff  = word | pad;

   assign req_in_pool = {1'b0, req_ch.id_value} < POOL_L;
   assign id_in_pool  = {1'b0, id_ff} < POOL_L;
   assign req_row     = req_ch.id_value[lfid_pkg::WORD_IW +: ROW_W];

   lfid_find #(
      .ROWS  (ROWS),
      .ROW_W (ROW_W)
   ) u_find (
      .row_full  (rowfull_ff),
      .word      (eff),
      .row_found (row_found),
      .row_idx   (row_idx),
      .bit_hit   (bit_hit)
   );

   // handshake outputs
   assign req_ch.ready      = (state_ff == lfid_pkg::ST_IDLE);
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.granted_id = grant_ff;
   assign rsp_ch.is_used    = used_ff;
   assign rsp_ch.pool_full  = full_ff;

   // sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lfid_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      id_ff        <= id_in;
      at_id_row_ff <= at_id_row_in;
      addr_ff      <= addr_in;
      grant_ff     <= grant_in;
      used_ff      <= used_in;
      full_ff      <= full_in;
   end

   // bitmap memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         used_mem[addr_ff] <= wr_word;
      end
      rdata_ff <= used_mem[addr_ff];
   end

   // row written and row full flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rowvld_ff  <= '0;
         rowfull_ff <= '0;
      end else if (wr_en) begin
         rowvld_ff[addr_ff]  <= 1'b1;
         rowfull_ff[addr_ff] <= &(wr_word | pad);
      end
   end

   // next state, memory write and response
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      id_in        = id_ff;
      at_id_row_in = at_id_row_ff;
      addr_in      = addr_ff;
      wr_en        = 1'b0;
      wr_word      = word;
      done         = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      grant_in     = grant_ff;
      used_in      = used_ff;
      full_in      = full_ff;

      case (state_ff)
         lfid_pkg::ST_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               id_in    = req_ch.id_value;
               state_in = lfid_pkg::ST_READ;
               if (req_ch.opcode == lfid_pkg::OP_ACQUIRE &&
                   !(req_ch.hint_valid && req_in_pool)) begin
                  // no usable hint: go straight to the lowest non-full row
                  addr_in      = row_idx;
                  at_id_row_in = 1'b0;
               end else begin
                  addr_in      = req_in_pool ? req_row : '0;
                  at_id_row_in = 1'b1;
               end
            end
         end

         lfid_pkg::ST_READ: begin
            state_in = lfid_pkg::ST_EVAL;
         end

         lfid_pkg::ST_EVAL: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               done     = 1'b1;
               state_in = lfid_pkg::ST_IDLE;
               grant_in = id_ff;
               used_in  = 1'b0;
               full_in  = 1'b0;
               case (op_ff)
                  lfid_pkg::OP_ACQUIRE: begin
                     if (at_id_row_ff && !eff[id_ff[lfid_pkg::WORD_IW-1:0]]) begin
                        // hint is free
                        wr_en = 1'b1;
                        wr_word[id_ff[lfid_pkg::WORD_IW-1:0]] = 1'b1;
                     end else if (at_id_row_ff && row_found) begin
                        // hint taken: rescan the lowest non-full row
                        done         = 1'b0;
                        addr_in      = row_idx;
                        at_id_row_in = 1'b0;
                        state_in     = lfid_pkg::ST_READ;
                     end else if (!row_found) begin
                        full_in = 1'b1;
                     end else begin
                        wr_en             = 1'b1;
                        wr_word[bit_hit.idx] = 1'b1;
                        grant_in = lfid_pkg::ID_W'({addr_ff, bit_hit.idx});
                     end
                  end
                  lfid_pkg::OP_RELEASE: begin
                     if (id_in_pool) begin
                        wr_en = 1'b1;
                        wr_word[id_ff[lfid_pkg::WORD_IW-1:0]] = 1'b0;
                     end
                  end
                  lfid_pkg::OP_QUERY: begin
                     used_in = id_in_pool && word[id_ff[lfid_pkg::WORD_IW-1:0]];
                  end
                  default: begin
                  end
               endcase
               if (done) begin
                  rsp_valid_in = 1'b1;
               end
            end
         end

         default: begin
            state_in = lfid_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a write back never overruns a response beat still waiting
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (!rsp_valid_ff || rsp_ch.ready))
      else $error("bitmap written while response register busy");

   // a written row reads as written from then on
   a_row_marked: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> rowvld_ff[$past(addr_ff)])
      else $error("written row not marked valid");

   // a successful acquire grants an id inside the pool
   a_grant_in_pool: assert property (@(posedge clock) disable iff (reset)
      (done && op_ff == lfid_pkg::OP_ACQUIRE && !full_in) |->
         ({1'b0, grant_in} < POOL_L))
      else $error("granted id outside the pool");

   // pool full is only reported when every row is full
   a_full_consistent: assert property (@(posedge clock) disable iff (reset)
      (done && full_in) |-> (&rowfull_ff))
      else $error("pool full reported with a free row");
`endif

endmodule

`default_nettype wire
